@@ sv/scanline_polygon_span_fill_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the scanline span fill block.
// ---------------------------------------------------------------------------
`ifndef SCANLINE_POLYGON_SPAN_FILL_DEFINES_SVH
`define SCANLINE_POLYGON_SPAN_FILL_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define SPF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define SPF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/spf_pkg.sv @@
// ---------------------------------------------------------------------------
// spf_pkg
// Shared constants and types for the scanline polygon span fill block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package spf_pkg;
  localparam int MaxVerticesDefault = 16;
  localparam int CoordBitsDefault   = 9;
  localparam int MaxSpans           = 8;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusFull  = 2'd1;
  localparam logic [1:0] StatusFew   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;    // capture the input item
    logic store_vtx;   // write vertex and bump count
    logic clear_cnt;   // empty the vertex list
    logic edge_load;   // read the current edge operands
    logic edge_next;   // advance edge index
    logic div_start;   // start one crossing division
    logic push_x;      // insert quotient into sorted list
    logic emit;        // emit one result
    logic emit_span;   // result carries a span
    logic [1:0] status;
    logic span_next;   // advance pair index
  } spf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_append;
    logic clear_req;
    logic full;
    logic few;
    logic edge_last;
    logic edge_hit;
    logic div_done;
    logic spans_none;
    logic span_last;
  } spf_stat_t;
endpackage

@@ sv/spf_ram.sv @@
// ---------------------------------------------------------------------------
// spf_ram
// Generic single-port-write, one-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module spf_ram #(
  parameter int Width = 9,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ sv/spf_div.sv @@
// ---------------------------------------------------------------------------
// spf_div
// Sequential signed divider, one quotient bit per cycle, truncating to zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module spf_div #(
  parameter int NumBits = 20,
  parameter int DenBits = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [NumBits-1:0] num,
  input  logic signed [DenBits-1:0] den,
  output logic signed [NumBits-1:0] quot,
  output logic                      done
);
  localparam int CntBits = $clog2(NumBits + 1);
  logic [NumBits-1:0] rem_q, acc;
  logic [DenBits-1:0] dmag;
  logic [NumBits:0]   trial;
  logic [CntBits-1:0] cnt;
  logic               neg, running;

  assign trial = {rem_q, acc[NumBits-1]} - {{(NumBits + 1 - DenBits){1'b0}}, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CntBits'(NumBits);
        acc     <= num[NumBits-1] ? NumBits'(-num) : num;
        dmag    <= den[DenBits-1] ? DenBits'(-den) : den;
        neg     <= num[NumBits-1] ^ den[DenBits-1];
        rem_q   <= '0;
      end else if (running) begin
        if (!trial[NumBits]) begin
          rem_q <= trial[NumBits-1:0];
          acc   <= {acc[NumBits-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[NumBits-2:0], acc[NumBits-1]};
          acc   <= {acc[NumBits-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntBits'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quot = neg ? -$signed(acc) : $signed(acc);
endmodule

@@ sv/spf_datapath.sv @@
// ---------------------------------------------------------------------------
// spf_datapath
// Vertex stores, edge walk, crossing division, sorted crossing list, output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "scanline_polygon_span_fill_defines.svh"
module spf_datapath #(
  parameter int MaxVertices = spf_pkg::MaxVerticesDefault,
  parameter int CoordBits   = spf_pkg::CoordBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 op,
  input  logic [CoordBits-1:0] coord_x,
  input  logic [CoordBits-1:0] coord_y,
  input  logic                 clear_first,
  input  spf_pkg::spf_cmd_t    cmd,
  output spf_pkg::spf_stat_t   stat,
  output logic                 strobe,
  output logic [CoordBits-1:0] row,
  output logic [CoordBits-1:0] span_start,
  output logic [CoordBits-1:0] span_end,
  output logic                 has_span,
  output logic [1:0]           status,
  output logic                 last
);
  localparam int AddrBits = $clog2(MaxVertices);
  localparam int CntBits  = $clog2(MaxVertices + 1);
  localparam int DBits    = CoordBits + 1;
  localparam int NBits    = 2 * CoordBits + 2;
  localparam int PairBits = $clog2(spf_pkg::MaxSpans);

  logic                 op_q, clr_q;
  logic [CoordBits-1:0] cx_q, cy_q;
  logic [CntBits-1:0]   count;
  logic [AddrBits-1:0]  eidx, raddr, waddr;
  logic                 phase;  // 0: first endpoint read, 1: second
  logic [CoordBits-1:0] xr, yr, xa, ya;
  logic signed [DBits-1:0] dy, yd, dx;
  logic signed [NBits-1:0] prod;
  logic signed [NBits-1:0] quot;
  logic                 div_done;
  logic [CoordBits-1:0] xs [MaxVertices];
  logic [CntBits-1:0]   nx;
  logic [PairBits:0]    pidx;
  logic [CoordBits-1:0] newx;
  logic [CntBits-1:0]   npairs;

  // A clearing append writes the first entry.
  assign waddr = cmd.clear_cnt ? '0 : count[AddrBits-1:0];

  spf_ram #(.Width(CoordBits), .Depth(MaxVertices)) u_xram (
    .clk, .we(cmd.store_vtx), .waddr, .wdata(cx_q),
    .raddr, .rdata(xr));
  spf_ram #(.Width(CoordBits), .Depth(MaxVertices)) u_yram (
    .clk, .we(cmd.store_vtx), .waddr, .wdata(cy_q),
    .raddr, .rdata(yr));

  // Wraps to entry zero after the last edge start.
  always_comb begin
    if (!phase) raddr = eidx;
    else if (CntBits'(eidx) + 1'b1 == count) raddr = '0;
    else raddr = AddrBits'(CntBits'(eidx) + 1'b1);
  end

  assign dy = $signed({1'b0, yr}) - $signed({1'b0, ya});
  assign yd = $signed({1'b0, cy_q}) - $signed({1'b0, ya});
  assign dx = $signed({1'b0, xr}) - $signed({1'b0, xa});

  spf_div #(.NumBits(NBits), .DenBits(DBits)) u_div (
    .clk, .rst, .start(cmd.div_start), .num(prod), .den(dy),
    .quot, .done(div_done));

  assign newx = CoordBits'(quot + $signed({{(NBits - CoordBits){1'b0}}, xa}));
  assign npairs = nx >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      phase <= 1'b0;
      eidx  <= '0;
      nx    <= '0;
      pidx  <= '0;
    end else begin
      if (cmd.latch_in) begin
        op_q  <= op;
        cx_q  <= coord_x;
        cy_q  <= coord_y;
        clr_q <= clear_first;
        phase <= 1'b0;
        eidx  <= '0;
        nx    <= '0;
        pidx  <= '0;
      end
      if (cmd.store_vtx) count <= (cmd.clear_cnt ? CntBits'(0) : count) + 1'b1;
      else if (cmd.clear_cnt) count <= '0;
      if (cmd.edge_load) begin
        if (!phase) begin
          xa <= xr;
          ya <= yr;
          phase <= 1'b1;
        end else begin
          prod <= NBits'(yd * dx);
        end
      end
      if (cmd.edge_next) begin
        eidx  <= eidx + 1'b1;
        phase <= 1'b0;
      end
      // Insertion into the sorted list: one shift of the tail per push.
      if (cmd.push_x) begin
        for (int i = 0; i < MaxVertices; i++) begin
          if (CntBits'(i) < nx) begin
            if (xs[i] > newx && i + 1 < MaxVertices) xs[i+1] <= xs[i];
          end
          if (CntBits'(i) <= nx) begin
            if ((i == 0 || xs[i > 0 ? i - 1 : 0] <= newx || CntBits'(i) == 0)
                && (CntBits'(i) == nx || xs[i] > newx)) begin
              if (i == 0 || !(xs[i > 0 ? i - 1 : 0] > newx)) xs[i] <= newx;
            end
          end
        end
        nx <= nx + 1'b1;
      end
      if (cmd.span_next) pidx <= pidx + 1'b1;
    end
  end

  always_comb begin
    stat.is_append  = !op_q;
    stat.clear_req  = clr_q;
    stat.full       = !clr_q && count >= CntBits'(MaxVertices);
    stat.few        = count < CntBits'(3);
    stat.edge_last  = CntBits'(eidx) + 1'b1 == count;
    stat.edge_hit   = dy != '0 &&
                      ((yr > ya) ? (cy_q > ya && cy_q <= yr) : (cy_q > yr && cy_q <= ya));
    stat.div_done   = div_done;
    stat.spans_none = npairs == '0;
    stat.span_last  = (CntBits'(pidx) + 1'b1 == npairs) ||
                      (pidx == (PairBits + 1)'(spf_pkg::MaxSpans - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) strobe <= 1'b0;
    else     strobe <= cmd.emit;
    if (cmd.emit) begin
      row        <= cy_q;
      has_span   <= cmd.emit_span;
      status     <= cmd.status;
      span_start <= cmd.emit_span ? xs[{pidx[PairBits-1:0], 1'b0}] : '0;
      span_end   <= cmd.emit_span ? xs[{pidx[PairBits-1:0], 1'b1}] : '0;
      last       <= !cmd.emit_span || stat.span_last;
    end
  end

  `SPF_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count <= CntBits'(MaxVertices),
    "vertex count beyond capacity")
  `SPF_ASSERT_NEXT(a_store_full, clk, rst, cmd.store_vtx && !cmd.clear_cnt,
    count != '0, "store left count at zero")
  `SPF_ASSERT_IMP(a_span_status, clk, rst, strobe && has_span, status == spf_pkg::StatusOk,
    "span result with error status")
endmodule

@@ sv/spf_ctrl.sv @@
// ---------------------------------------------------------------------------
// spf_ctrl
// Sequencer for vertex append and row query with edge walk and span output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "scanline_polygon_span_fill_defines.svh"
module spf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  spf_pkg::spf_stat_t stat,
  output spf_pkg::spf_cmd_t  cmd
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DEC   = 10'b0000000010,
    S_RD0   = 10'b0000000100,
    S_RD1   = 10'b0000001000,
    S_RD2   = 10'b0000010000,
    S_MUL   = 10'b0000100000,
    S_DIV   = 10'b0001000000,
    S_WAIT  = 10'b0010000000,
    S_NEXT  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state, state_next;

  assign busy = state != S_IDLE;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch_in = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.is_append) begin
          if (stat.clear_req) cmd.clear_cnt = 1'b1;
          cmd.emit = 1'b1;
          if (stat.full) cmd.status = spf_pkg::StatusFull;
          else begin
            cmd.store_vtx = 1'b1;
            cmd.status = spf_pkg::StatusOk;
          end
          state_next = S_IDLE;
        end else if (stat.few) begin
          cmd.emit = 1'b1;
          cmd.status = spf_pkg::StatusFew;
          state_next = S_IDLE;
        end else state_next = S_RD0;
      end
      S_RD0: state_next = S_RD1;          // first endpoint read in flight
      S_RD1: begin
        cmd.edge_load = 1'b1;              // capture first endpoint
        state_next = S_RD2;
      end
      S_RD2: state_next = S_MUL;          // second endpoint read in flight
      S_MUL: begin
        cmd.edge_load = 1'b1;              // second endpoint valid, form product
        state_next = stat.edge_hit ? S_DIV : S_NEXT;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (stat.div_done) begin
          cmd.push_x = 1'b1;
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        if (stat.edge_last) begin
          if (stat.spans_none) begin
            cmd.emit = 1'b1;
            cmd.status = spf_pkg::StatusOk;
            state_next = S_IDLE;
          end else state_next = S_OUT;
        end else begin
          cmd.edge_next = 1'b1;
          state_next = S_RD0;
        end
      end
      S_OUT: begin
        cmd.emit = 1'b1;
        cmd.emit_span = 1'b1;
        cmd.span_next = 1'b1;
        cmd.status = spf_pkg::StatusOk;
        if (stat.span_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  `SPF_ASSERT_IMP(a_onehot, clk, rst, 1'b1, $onehot(state), "state not one-hot")
  `SPF_ASSERT_NEXT(a_accept, clk, rst, start && !busy, busy, "accepted item left idle")
  `SPF_ASSERT_IMP(a_emit_busy, clk, rst, cmd.emit, busy, "emit while idle")
endmodule

@@ sv/scanline_polygon_span_fill.sv @@
// ---------------------------------------------------------------------------
// scanline_polygon_span_fill
// Polygon vertex list with per-row span computation.
// ---------------------------------------------------------------------------
// Channel | Handshake        | Fields
// input   | start, busy      | op, coord_x, coord_y, clear_first
// result  | strobe           | row, span_start, span_end, has_span, status, last
//
// An append is latched at start and decided in S_DEC, which registers its result strobe.
// A row query reads each edge, runs the bit-serial divider for every crossing,
// then emits one span per cycle, or a single result without a span if none.
// rst is synchronous and empties the vertex list; stored coordinates keep no reset.
// The receiver cannot stall; busy stays high until the last result is out.
`timescale 1ns / 1ps
module scanline_polygon_span_fill #(
  parameter int MaxVertices = spf_pkg::MaxVerticesDefault,
  parameter int CoordBits   = spf_pkg::CoordBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 op,
  input  logic [CoordBits-1:0] coord_x,
  input  logic [CoordBits-1:0] coord_y,
  input  logic                 clear_first,
  output logic                 strobe,
  output logic [CoordBits-1:0] row,
  output logic [CoordBits-1:0] span_start,
  output logic [CoordBits-1:0] span_end,
  output logic                 has_span,
  output logic [1:0]           status,
  output logic                 last
);
  spf_pkg::spf_cmd_t  cmd;
  spf_pkg::spf_stat_t stat;
  logic               ctrl_busy;

  spf_ctrl u_ctrl (.clk, .rst, .start, .busy(ctrl_busy), .stat, .cmd);

  // busy also stays high while a strobed result that is not the last one is in the output register.
  assign busy = ctrl_busy || (strobe && !last);

  spf_datapath #(.MaxVertices(MaxVertices), .CoordBits(CoordBits)) u_dp (
    .clk, .rst, .op, .coord_x, .coord_y, .clear_first, .cmd, .stat,
    .strobe, .row, .span_start, .span_end, .has_span, .status, .last);
endmodule
